/* hdl/srcs_pkg.sv */
// Shared constants, types and state codes for the sparse row column sorter.
package srcs_pkg;

   localparam int MAX_ROW_LEN = 32;
   localparam int COLUMN_BITS = 16;

   localparam int IN_COL_W   = 16;
   localparam int VALUE_W    = 64;
   localparam int COL_W      = (COLUMN_BITS < IN_COL_W) ? COLUMN_BITS : IN_COL_W;
   localparam int COUNT_BITS = $clog2(MAX_ROW_LEN + 1);

   typedef struct packed {
      logic [COL_W-1:0]   col;
      logic [VALUE_W-1:0] value;
   } srcs_entry_type;

   typedef struct packed {
      logic           insert;
      logic           shift;
      srcs_entry_type new_entry;
   } srcs_cell_ctl_type;

   typedef enum logic {
      ST_COLLECT,
      ST_EMIT
   } srcs_state_type;

endpackage

/* hdl/srcs_if.sv */
// Valid/ready channel interfaces for row entries and sorted results.
interface srcs_req_if;
   logic                                valid;
   logic                                ready;
   logic [srcs_pkg::IN_COL_W-1:0]       column;
   logic [srcs_pkg::VALUE_W-1:0]        value_bits;
   logic                                row_end;

   modport source (output valid, output column, output value_bits, output row_end,
                   input ready);
   modport sink   (input valid, input column, input value_bits, input row_end,
                   output ready);
endinterface

interface srcs_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [srcs_pkg::IN_COL_W-1:0]       sorted_column;
   logic [srcs_pkg::VALUE_W-1:0]        sorted_value;
   logic                                last_of_row;
   logic                                row_overflow;

   modport source (output valid, output sorted_column, output sorted_value,
                   output last_of_row, output row_overflow, input ready);
   modport sink   (input valid, input sorted_column, input sorted_value,
                   input last_of_row, input row_overflow, output ready);
endinterface

/* hdl/srcs_cell.sv */
// One slot of the insertion chain: holds an entry, inserts or shifts when the chain control says so.
module srcs_cell (
   input  logic                        clock,
   input  srcs_pkg::srcs_cell_ctl_type ctl,
   input  logic                        occupied,
   input  logic                        prev_keep,
   input  srcs_pkg::srcs_entry_type    prev_data,
   input  srcs_pkg::srcs_entry_type    next_data,
   output logic                        keep_out,
   output srcs_pkg::srcs_entry_type    data_out
);
   import srcs_pkg::*;

   srcs_entry_type data_ff;
   srcs_entry_type data_in;
   logic           keep;

   // Equal columns stay ahead of the newcomer, which keeps arrival order.
   assign keep = occupied && (data_ff.col <= ctl.new_entry.col);

   always_comb begin
      data_in = data_ff;
      if (ctl.shift) begin
         data_in = next_data;
      end else if (ctl.insert && !keep) begin
         data_in = prev_keep ? ctl.new_entry : prev_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign keep_out = keep;
   assign data_out = data_ff;

endmodule

/* hdl/sparse_row_column_sorter_core.sv */
// Flow: an entry is accepted whenever the block is collecting; after the row-end transfer
//   the first result is offered in the next cycle and the rest follow one per cycle while
//   the result side is ready. No new entry is taken while a row is being emitted, since
//   the single chain of MAX_ROW_LEN insertion cells is filled then drained.
// Reset: synchronous, clears the entry count, overflow flag and state; cell
//   contents are not cleared and need no clearing pass.
module sparse_row_column_sorter_core (
   input  logic       clock,
   input  logic       reset,
   srcs_req_if.sink   req_ch,
   srcs_rsp_if.source rsp_ch
);
   import srcs_pkg::*;

   srcs_state_type        state_ff, state_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic                  ovf_ff, ovf_in;

   logic                  req_xfer;
   logic                  rsp_xfer;
   logic                  room;
   logic                  last_one;
   srcs_cell_ctl_type     cell_ctl;
   srcs_entry_type        cell_data [MAX_ROW_LEN];
   logic                  cell_keep [MAX_ROW_LEN];

   assign req_xfer = req_ch.valid && req_ch.ready;
   assign rsp_xfer = rsp_ch.valid && rsp_ch.ready;
   assign room     = count_ff < COUNT_BITS'(MAX_ROW_LEN);
   assign last_one = count_ff == COUNT_BITS'(1);

   assign cell_ctl.insert          = req_xfer && room;
   assign cell_ctl.shift           = rsp_xfer;
   assign cell_ctl.new_entry.col   = COL_W'(req_ch.column);
   assign cell_ctl.new_entry.value = req_ch.value_bits;

   genvar gi;
   generate
      for (gi = 0; gi < MAX_ROW_LEN; gi++) begin : g_cell
         logic           prev_keep;
         srcs_entry_type prev_data;
         srcs_entry_type next_data;
         logic           occupied;

         assign occupied = COUNT_BITS'(gi) < count_ff;

         if (gi == 0) begin : g_head
            assign prev_keep = 1'b1;
            assign prev_data = cell_ctl.new_entry;
         end else begin : g_body
            assign prev_keep = cell_keep[gi-1];
            assign prev_data = cell_data[gi-1];
         end

         if (gi == MAX_ROW_LEN - 1) begin : g_tail
            assign next_data = cell_data[gi];
         end else begin : g_mid
            assign next_data = cell_data[gi+1];
         end

         srcs_cell u_cell (
            .clock     (clock),
            .ctl       (cell_ctl),
            .occupied  (occupied),
            .prev_keep (prev_keep),
            .prev_data (prev_data),
            .next_data (next_data),
            .keep_out  (cell_keep[gi]),
            .data_out  (cell_data[gi])
         );
      end
   endgenerate

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_COLLECT: begin
            if (req_xfer && req_ch.row_end) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (rsp_xfer && last_one) begin
               state_in = ST_COLLECT;
            end
         end
         default: state_in = ST_COLLECT;
      endcase
   end

   // Outputs
   always_comb begin
      req_ch.ready         = 1'b0;
      rsp_ch.valid         = 1'b0;
      case (state_ff)
         ST_COLLECT: req_ch.ready = 1'b1;
         ST_EMIT:    rsp_ch.valid = 1'b1;
         default: begin
            req_ch.ready = 1'b0;
            rsp_ch.valid = 1'b0;
         end
      endcase
      rsp_ch.sorted_column = IN_COL_W'(cell_data[0].col);
      rsp_ch.sorted_value  = cell_data[0].value;
      rsp_ch.last_of_row   = last_one;
      rsp_ch.row_overflow  = ovf_ff;
   end

   always_comb begin
      count_in = count_ff;
      ovf_in   = ovf_ff;
      if (cell_ctl.insert) begin
         count_in = count_ff + COUNT_BITS'(1);
      end else if (rsp_xfer) begin
         count_in = count_ff - COUNT_BITS'(1);
      end
      // drop the entry when the row is full and flag the row
      if (req_xfer && !room) begin
         ovf_in = 1'b1;
      end else if (rsp_xfer && last_one) begin
         ovf_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_COLLECT;
         count_ff <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
      end
   end

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_BITS'(MAX_ROW_LEN))
      else $error("entry count beyond row capacity");

   a_emit_nonempty: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> count_ff != '0)
      else $error("result offered with no stored entry");

   a_row_end_emits: assert property (@(posedge clock) disable iff (reset)
      req_xfer && req_ch.row_end |=> rsp_ch.valid && !req_ch.ready)
      else $error("row end did not start emission");

   a_row_clears: assert property (@(posedge clock) disable iff (reset)
      rsp_xfer && rsp_ch.last_of_row |=> count_ff == '0 && !ovf_ff)
      else $error("row state not cleared after last result");

   a_head_sorted: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && count_ff >= COUNT_BITS'(2) |-> cell_data[0].col <= cell_data[1].col)
      else $error("chain head out of column order");
`endif

endmodule

/* dv/tb_sparse_row_column_sorter_core.sv */
// Testbench for sparse_row_column_sorter_core: directed and random rows, stable-sort prediction, checks.
module tb_sparse_row_column_sorter_core;
   timeunit 1ns;
   timeprecision 1ps;
   import srcs_pkg::*;

   localparam int TARGET_ENTRIES = 370;
   localparam int IDLE_LIMIT     = 2000;
   localparam int DRAIN_CYCLES   = 40;

   typedef struct {
      logic [COL_W-1:0]   col;
      logic [VALUE_W-1:0] value;
      logic               last;
      logic               overflow;
   } sorted_entry_type;

   class row_order_scoreboard;
      logic [COL_W-1:0]   row_cols[$];
      logic [VALUE_W-1:0] row_values[$];
      bit                 overflowed;
      sorted_entry_type   sorted_q[$];
      int                 failures;

      function void note_entry(logic [IN_COL_W-1:0] column, logic [VALUE_W-1:0] value,
                               logic row_end);
         logic [COL_W-1:0]   c;
         logic [VALUE_W-1:0] v;
         int                 j;
         sorted_entry_type   e;
         if (row_cols.size() < MAX_ROW_LEN) begin
            row_cols.push_back(column[COL_W-1:0]);
            row_values.push_back(value);
         end else begin
            overflowed = 1;
         end
         if (row_end) begin
            // insertion sort, strict compare keeps equal columns in arrival order
            for (int i = 1; i < row_cols.size(); i++) begin
               c = row_cols[i];
               v = row_values[i];
               j = i;
               while (j > 0 && row_cols[j-1] > c) begin
                  row_cols[j]   = row_cols[j-1];
                  row_values[j] = row_values[j-1];
                  j--;
               end
               row_cols[j]   = c;
               row_values[j] = v;
            end
            foreach (row_cols[k]) begin
               e.col      = row_cols[k];
               e.value    = row_values[k];
               e.last     = (k == row_cols.size() - 1);
               e.overflow = overflowed;
               sorted_q.push_back(e);
            end
            row_cols.delete();
            row_values.delete();
            overflowed = 0;
         end
      endfunction

      function void check_result(logic [IN_COL_W-1:0] column, logic [VALUE_W-1:0] value,
                                 logic last, logic overflow);
         sorted_entry_type e;
         if (sorted_q.size() == 0) begin
            $error("unexpected result: column %h value %h", column, value);
            failures++;
            return;
         end
         e = sorted_q.pop_front();
         if (column !== IN_COL_W'(e.col)) begin
            $error("sorted_column: expected %h, actual %h", e.col, column);
            failures++;
         end
         if (value !== e.value) begin
            $error("sorted_value: expected %h, actual %h", e.value, value);
            failures++;
         end
         if (last !== e.last) begin
            $error("last_of_row: expected %b, actual %b", e.last, last);
            failures++;
         end
         if (overflow !== e.overflow) begin
            $error("row_overflow: expected %b, actual %b", e.overflow, overflow);
            failures++;
         end
      endfunction

      function int pending();
         return sorted_q.size();
      endfunction
   endclass

   logic clock;
   logic reset;
   int   entries_sent;

   srcs_req_if req_ch ();
   srcs_rsp_if rsp_ch ();

   row_order_scoreboard sb = new;

   sparse_row_column_sorter_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // mostly short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [VALUE_W-1:0] pick_value();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) return '0;
      if (r < 20) return '1;
      return {$urandom, $urandom};
   endfunction

   function automatic int pick_row_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return $urandom_range(1, 6);
      if (r < 80) return $urandom_range(7, MAX_ROW_LEN - 1);
      if (r < 90) return MAX_ROW_LEN;
      return $urandom_range(MAX_ROW_LEN + 1, MAX_ROW_LEN + 8);
   endfunction

   task automatic send_entry(input logic [IN_COL_W-1:0] column,
                             input logic [VALUE_W-1:0] value,
                             input logic row_end, input bit steady);
      int gap;
      gap = steady ? 0 : pick_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.column     <= column;
      req_ch.value_bits <= value;
      req_ch.row_end    <= row_end;
      do @(posedge clock); while (!req_ch.ready);
      sb.note_entry(column, value, row_end);
      entries_sent++;
   endtask

   // column modes: full range, narrow range (many ties), extremes, descending
   task automatic send_row(input int len, input int col_mode);
      bit                    steady;
      logic [IN_COL_W-1:0]   base;
      logic [IN_COL_W-1:0]   column;
      steady = ($urandom_range(0, 3) == 0);
      base   = IN_COL_W'($urandom_range(len, 16'hFFFF));
      for (int i = 0; i < len; i++) begin
         case (col_mode)
            0: column = IN_COL_W'($urandom_range(0, 16'hFFFF));
            1: column = IN_COL_W'($urandom_range(0, 7));
            2: begin
               case ($urandom_range(0, 2))
                  0: column = '0;
                  1: column = '1;
                  default: column = IN_COL_W'($urandom_range(0, 16'hFFFF));
               endcase
            end
            default: column = base - IN_COL_W'(i);
         endcase
         send_entry(column, pick_value(), i == len - 1, steady);
      end
   endtask

   // drop valid so the last entry is not taken again once the block reopens
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (sb.pending() > 0) @(posedge clock);
   endtask

   // result side: random stalls with occasional long stretches of steady ready
   initial begin
      int stall;
      int steady;
      int r;
      stall  = 0;
      steady = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (steady > 0) begin
            steady--;
            rsp_ch.ready <= 1'b1;
         end else if (stall > 0) begin
            stall--;
            rsp_ch.ready <= 1'b0;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 5) begin
               steady = $urandom_range(20, 80);
               rsp_ch.ready <= 1'b1;
            end else if (r < 70) begin
               rsp_ch.ready <= 1'b1;
            end else begin
               stall = pick_gap();
               rsp_ch.ready <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         sb.check_result(rsp_ch.sorted_column, rsp_ch.sorted_value,
                         rsp_ch.last_of_row, rsp_ch.row_overflow);
   end

   // end the run once no transfer has happened on either side for too long
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("tb_sparse_row_column_sorter_core NOT OK");
      $finish;
   end

   initial begin
      entries_sent = 0;
      reset             <= 1'b1;
      req_ch.valid      <= 1'b0;
      req_ch.column     <= '0;
      req_ch.value_bits <= '0;
      req_ch.row_end    <= 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // one-entry rows at the field extremes pass through unchanged
      send_entry(16'hFFFF, '1, 1'b1, 1'b0);
      send_entry(16'h0000, '0, 1'b1, 1'b0);
      // ties must come out in arrival order
      send_entry(16'd5, 64'h1, 1'b0, 1'b0);
      send_entry(16'd3, 64'h2, 1'b0, 1'b0);
      send_entry(16'd5, 64'h3, 1'b0, 1'b0);
      send_entry(16'h0000, 64'h4, 1'b0, 1'b0);
      send_entry(16'hFFFF, 64'h5, 1'b0, 1'b0);
      send_entry(16'd3, 64'h6, 1'b1, 1'b0);
      // already ascending
      send_entry(16'd1, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 1'b0);
      send_entry(16'd2, 64'h5555_5555_5555_5555, 1'b0, 1'b0);
      send_entry(16'd3, 64'h8000_0000_0000_0001, 1'b1, 1'b0);
      // strictly descending
      send_entry(16'hFFFE, 64'h10, 1'b0, 1'b0);
      send_entry(16'h8000, 64'h11, 1'b0, 1'b0);
      send_entry(16'h7FFF, 64'h12, 1'b0, 1'b0);
      send_entry(16'h0001, 64'h13, 1'b1, 1'b0);
      wait_drained();

      // one row past capacity, then one exactly at capacity
      send_row(MAX_ROW_LEN + 1, 0);
      send_row(MAX_ROW_LEN, 1);

      while (entries_sent < TARGET_ENTRIES) begin
         send_row(pick_row_len(), $urandom_range(0, 3));
         // hold off now and then until every pending result is out
         if ($urandom_range(0, 7) == 0)
            wait_drained();
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.failures == 0 && sb.pending() == 0)
         $display("tb_sparse_row_column_sorter_core OK");
      else
         $display("tb_sparse_row_column_sorter_core NOT OK");
      $finish;
   end

endmodule
